// ===== rtl/btpd_pkg.sv =====
// Shared types and constants for the binary to padded decimal ASCII converter.
package btpd_pkg;

    localparam int BIN_W       = 64;               // width of the binary input value
    localparam int BIT_CNT_W   = $clog2(BIN_W);    // conversion step counter
    localparam int REQ_W       = 7;                // width of the min_digits field
    localparam int DIGIT_W     = 4;                // one BCD digit
    localparam int NUM_DIGITS  = 20;               // decimal digits of the largest 64-bit value
    localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W      = 6;                // width of char_code
    localparam int IN_DATA_W   = 72;               // value and min_digits padded to bytes
    localparam int OUT_DATA_W  = 8;                // char_code padded to a byte

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = DIGIT_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } t_state;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_chain_ctl;

endpackage

// ===== rtl/btpd_cell.sv =====
// One BCD digit cell of the double-dabble chain.
module btpd_cell
    import btpd_pkg::*;
(
    input  logic               i_clk,
    input  t_chain_ctl         i_ctl,
    input  logic               i_bit,
    output logic               o_bit,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] w_adj;

    // Add three before the shift so the doubled digit carries at ten.
    assign w_adj   = (r_digit >= BCD_ADJ_MIN) ? (r_digit + BCD_ADJ_ADD) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.shift) begin
            r_digit <= {w_adj[DIGIT_W-2:0], i_bit};
        end
    end

endmodule

// ===== rtl/btpd_digit_chain.sv =====
// Row of BCD cells that turns a serial binary stream into decimal digits.
module btpd_digit_chain
    import btpd_pkg::*;
(
    input  logic                                 i_clk,
    input  t_chain_ctl                           i_ctl,
    input  logic                                 i_bit,
    output logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   o_digits,
    output logic [DIG_CNT_W-1:0]                 o_ndig
);

    logic [NUM_DIGITS:0] w_carry;

    assign w_carry[0] = i_bit;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        btpd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (w_carry[g]),
            .o_bit   (w_carry[g+1]),
            .o_digit (o_digits[g])
        );
    end

    // Significant digit count: highest nonzero digit plus one, at least one.
    always_comb begin
        o_ndig = DIG_CNT_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (o_digits[i] != '0) begin
                o_ndig = DIG_CNT_W'(i + 1);
            end
        end
    end

endmodule

// ===== rtl/binary_to_padded_decimal_ascii.sv =====
// Top level: 64-bit unsigned binary to zero-padded decimal ASCII character stream.
//
// Input channel (s side): one beat carries value in tdata[63:0] and min_digits in
// tdata[70:64]. Output channel (m side): one beat per character, char_code in
// tdata[5:0], tlast high on the final character of the number.
// Characters leave most significant digit first; zero gives a single '0'; leading
// '0' characters are added until min_digits is reached, min_digits above MAX_CHARS
// counts as MAX_CHARS.
// One item at a time: after an input beat, a chain of 20 BCD cells takes in the
// value one input bit per cycle, a counting step finds the significant digits,
// then one character is loaded per cycle into the output register while the
// receiver keeps up. An item gives N characters (N = 1..MAX_CHARS); o_s_tready
// rises again in the same cycle that the last character first sits in the
// output register, so the next item is taken while that character waits for the receiver.
// When the receiver stalls, the output register holds its beat and the emit
// counter holds; conversion itself never waits.
// Synchronous active-low reset returns to idle and drops o_m_tvalid.
module binary_to_padded_decimal_ascii
    import btpd_pkg::*;
#(
    parameter int MAX_CHARS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [63:0] value, [70:64] min_digits, [71] zero
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                  o_m_tlast
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    t_state                             r_state;
    t_state                             n_state;
    logic [BIN_W-1:0]                   r_bin;
    logic [BIT_CNT_W-1:0]               r_bit_cnt;
    logic [CW-1:0]                      r_req;
    logic [CW-1:0]                      r_pos;
    logic                               r_out_valid;
    logic [CHAR_W-1:0]                  r_out_char;
    logic                               r_out_last;

    t_chain_ctl                         w_ctl;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] w_digits;
    logic [DIG_CNT_W-1:0]               w_ndig;
    logic [CW-1:0]                      w_total;
    logic [CW-1:0]                      w_req_sat;
    logic [DIGIT_W-1:0]                 w_sel_digit;
    logic                               w_in_beat;
    logic                               w_out_load;
    logic                               w_conv_done;
    logic                               w_emit_done;

    btpd_digit_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_bit    (r_bin[BIN_W-1]),
        .o_digits (w_digits),
        .o_ndig   (w_ndig)
    );

    assign w_in_beat   = i_s_tvalid && o_s_tready;
    assign w_conv_done = (r_bit_cnt == BIT_CNT_W'(BIN_W - 1));
    assign w_emit_done = (r_pos == '0);

    // Saturate the requested width.
    assign w_req_sat = (i_s_tdata[BIN_W +: REQ_W] > REQ_W'(MAX_CHARS))
                     ? CW'(MAX_CHARS) : CW'(i_s_tdata[BIN_W +: REQ_W]);

    assign w_total = (CW'(w_ndig) > r_req) ? CW'(w_ndig) : r_req;

    // Positions above the top cell are padding zeros.
    always_comb begin
        w_sel_digit = '0;
        if (r_pos < CW'(NUM_DIGITS)) begin
            w_sel_digit = w_digits[r_pos[DIG_IDX_W-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_beat)                 n_state = ST_CONV;
            ST_CONV:  if (w_conv_done)               n_state = ST_COUNT;
            ST_COUNT:                                n_state = ST_EMIT;
            ST_EMIT:  if (w_out_load && w_emit_done) n_state = ST_IDLE;
            default:                                 n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        w_ctl       = '0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                w_ctl.clear = w_in_beat;
            end
            ST_CONV: begin
                w_ctl.shift = 1'b1;
            end
            ST_COUNT: begin
            end
            ST_EMIT: begin
                w_out_load = !r_out_valid || i_m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_bin     <= i_s_tdata[BIN_W-1:0];
            r_req     <= w_req_sat;
            r_bit_cnt <= '0;
        end else if (r_state == ST_CONV) begin
            r_bin     <= {r_bin[BIN_W-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
        end
        if (r_state == ST_COUNT) begin
            r_pos <= w_total - CW'(1);
        end else if (w_out_load && !w_emit_done) begin
            r_pos <= r_pos - CW'(1);
        end
        if (w_out_load) begin
            r_out_char <= ASCII_ZERO | CHAR_W'(w_sel_digit);
            r_out_last <= w_emit_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out_char);
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/btpd_checker.sv =====
// Port-level checks for the binary to padded decimal ASCII converter, bound to the top.
module btpd_checker
    import btpd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    a_reset_drops_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed under stall");

    a_char_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >= OUT_DATA_W'(48)) && (o_m_tdata <= OUT_DATA_W'(57)))
        else $error("output beat is not a decimal digit");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready ##1 !o_s_tready)
        else $error("input taken during conversion");

    a_no_output_while_converting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("output beat appeared right after an input beat");

endmodule

bind binary_to_padded_decimal_ascii btpd_checker u_btpd_checker (.*);
